// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the allocator modules
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every edge out of reset
`define ASA_CHECK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// antecedent at one edge, consequent at the next
`define ASA_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASA_CHECK(lbl, clk, rstn, prop, msg)
`define ASA_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/asa_pkg.sv =====
// shared types and fixed constants of the shelf allocator
// no dependencies
package asa_pkg;

	localparam int CONTENT_W = 11;
	localparam int FOOT_W    = 12;
	localparam int PAGE_IDX_W = 4;
	localparam int COORD_W   = 10;
	localparam int LIMIT_W   = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd4;
	localparam logic [FOOT_W-1:0]  PAD_TOTAL   = 12'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic load_req;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic finish;
	} status_t;

endpackage

// ===== rtl/core/asa_ifs.sv =====
// request and response channels of the shelf allocator
// depends on asa_pkg for field widths
interface asa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic                          glyph;
	logic [asa_pkg::CONTENT_W-1:0] content_width;
	logic [asa_pkg::CONTENT_W-1:0] content_height;

	modport source (output valid, func, glyph, content_width, content_height, input ready);
	modport sink (input valid, func, glyph, content_width, content_height, output ready);
endinterface

interface asa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           placed;
	logic [asa_pkg::PAGE_IDX_W-1:0] page_index;
	logic [asa_pkg::COORD_W-1:0]    content_x;
	logic [asa_pkg::COORD_W-1:0]    content_y;

	modport source (output valid, placed, page_index, content_x, content_y, input ready);
	modport sink (input valid, placed, page_index, content_x, content_y, output ready);
endinterface

// ===== rtl/core/asa_ctrl.sv =====
// sequencing state machine: takes a word, steps the page walk, loads the result
// depends on asa_pkg and assert_macros.svh
`include "assert_macros.svh"

module asa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output asa_pkg::cmd_t     cmd,
	input  asa_pkg::status_t  status
);

	typedef enum logic [0:0] {ST_IDLE, ST_WALK} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_req = in_valid && (state_q == ST_IDLE);
		cmd.step     = (state_q == ST_WALK) && (!status.finish || out_free);
		cmd.load_out = (state_q == ST_WALK) && status.finish && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (status.finish && out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`ASA_CHECK_NEXT(a_accept_walk, clk, arst_n, in_valid && in_ready, state_q == ST_WALK, "accepted word did not start a walk")
	`ASA_CHECK_NEXT(a_stall_hold, clk, arst_n, (state_q == ST_WALK) && status.finish && !out_free, (state_q == ST_WALK) && out_valid_q, "finished walk left while result blocked")
	`ASA_CHECK(a_rise_from_walk, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_WALK), "result appeared without a walk")

endmodule

// ===== rtl/core/asa_datapath.sv =====
// page table, shelf arithmetic, kind counters, limit register and result register
// depends on asa_pkg and assert_macros.svh
`include "assert_macros.svh"

module asa_datapath #(
	parameter int PAGE_EDGE  = 1024,
	parameter int PAGE_LIMIT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  asa_pkg::cmd_t                    cmd,
	output asa_pkg::status_t                 status,
	input  logic                             cfg_we,
	input  logic [asa_pkg::LIMIT_W-1:0]      cfg_data,
	input  logic                             req_func,
	input  logic                             req_glyph,
	input  logic [asa_pkg::CONTENT_W-1:0]    req_content_width,
	input  logic [asa_pkg::CONTENT_W-1:0]    req_content_height,
	output logic                             rsp_placed,
	output logic [asa_pkg::PAGE_IDX_W-1:0]   rsp_page_index,
	output logic [asa_pkg::COORD_W-1:0]      rsp_content_x,
	output logic [asa_pkg::COORD_W-1:0]      rsp_content_y
);

	localparam int CW = $clog2(PAGE_EDGE + 1);
	localparam int FW = ((CW > asa_pkg::FOOT_W) ? CW : asa_pkg::FOOT_W) + 2;
	localparam int OW = $clog2(PAGE_LIMIT + 1);
	localparam int PW = (PAGE_LIMIT > 1) ? $clog2(PAGE_LIMIT) : 1;
	localparam int KW = (OW > asa_pkg::LIMIT_W) ? OW : asa_pkg::LIMIT_W;
	localparam logic [FW-1:0] EDGE = FW'(PAGE_EDGE);

	logic [asa_pkg::LIMIT_W-1:0] limit_q;
	logic [OW-1:0]               open_pages_q;
	logic [OW-1:0]               cnt_img_q;
	logic [OW-1:0]               cnt_gly_q;
	logic [OW-1:0]               page_q;
	logic                        req_func_q;
	logic                        req_kind_q;
	logic [asa_pkg::FOOT_W-1:0]  fw_q;
	logic [asa_pkg::FOOT_W-1:0]  fh_q;

	logic          page_kind_q [PAGE_LIMIT];
	logic [CW-1:0] page_cx_q   [PAGE_LIMIT];
	logic [CW-1:0] page_ty_q   [PAGE_LIMIT];
	logic [CW-1:0] page_sh_q   [PAGE_LIMIT];

	logic [PW-1:0] idx;
	logic          is_new, at_end, limit_hit, blocked, kind_ok, wrap, fits;
	logic          slot_ok, hit, open_now;
	logic [OW-1:0] kind_cnt;
	logic [CW-1:0] cur_x, cur_y, cur_row;
	logic [FW-1:0] sum_x, new_x, new_y, new_row, fh_ext, fw_ext, row_max;

	assign idx      = page_q[PW-1:0];
	assign is_new   = (page_q == open_pages_q);
	assign at_end   = (page_q == OW'(PAGE_LIMIT));
	assign kind_cnt = req_kind_q ? cnt_gly_q : cnt_img_q;
	assign limit_hit = KW'(kind_cnt) >= KW'(limit_q);
	assign blocked  = is_new && limit_hit;

	// a page about to open reads as an empty page
	assign cur_x   = is_new ? '0 : page_cx_q[idx];
	assign cur_y   = is_new ? '0 : page_ty_q[idx];
	assign cur_row = is_new ? '0 : page_sh_q[idx];
	assign kind_ok = is_new || (page_kind_q[idx] == req_kind_q);

	assign fw_ext  = FW'(fw_q);
	assign fh_ext  = FW'(fh_q);
	assign sum_x   = FW'(cur_x) + fw_ext;
	assign wrap    = sum_x > EDGE;
	assign new_x   = wrap ? '0 : FW'(cur_x);
	assign new_y   = wrap ? (FW'(cur_y) + FW'(cur_row)) : FW'(cur_y);
	assign new_row = wrap ? '0 : FW'(cur_row);
	assign row_max = (new_row > fh_ext) ? new_row : fh_ext;
	assign fits    = kind_ok && ((new_y + fh_ext) <= EDGE) && (fw_ext <= EDGE);

	assign slot_ok  = !req_func_q && !at_end && !blocked;
	assign hit      = slot_ok && fits;
	assign open_now = slot_ok && is_new;

	assign status.finish = req_func_q || at_end || blocked || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= asa_pkg::LIMIT_RESET;
			open_pages_q <= '0;
			cnt_img_q    <= '0;
			cnt_gly_q    <= '0;
			page_q       <= '0;
			req_func_q   <= asa_pkg::FUNC_ALLOC;
			req_kind_q   <= 1'b0;
			fw_q         <= '0;
			fh_q         <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			if (cmd.load_req) begin
				req_func_q <= req_func;
				req_kind_q <= req_glyph;
				fw_q       <= asa_pkg::FOOT_W'(req_content_width) + asa_pkg::PAD_TOTAL;
				fh_q       <= asa_pkg::FOOT_W'(req_content_height) + asa_pkg::PAD_TOTAL;
				page_q     <= '0;
			end else if (cmd.step) begin
				if (req_func_q == asa_pkg::FUNC_CLEAR) begin
					open_pages_q <= '0;
					cnt_img_q    <= '0;
					cnt_gly_q    <= '0;
				end else begin
					if (!status.finish) page_q <= OW'(page_q + 1'b1);
					if (open_now) begin
						open_pages_q <= OW'(open_pages_q + 1'b1);
						if (req_kind_q) cnt_gly_q <= OW'(cnt_gly_q + 1'b1);
						else cnt_img_q <= OW'(cnt_img_q + 1'b1);
					end
				end
			end
		end
	end

	// page table: a freshly opened page is written even when the item misses it
	always_ff @(posedge clk) begin
		if (cmd.step && (open_now || hit)) begin
			page_kind_q[idx] <= req_kind_q;
			page_cx_q[idx]   <= hit ? CW'(new_x + fw_ext) : '0;
			page_ty_q[idx]   <= hit ? CW'(new_y) : '0;
			page_sh_q[idx]   <= hit ? CW'(row_max) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_placed     <= hit;
			rsp_page_index <= hit ? asa_pkg::PAGE_IDX_W'(page_q) : '0;
			rsp_content_x  <= hit ? asa_pkg::COORD_W'(new_x + FW'(1)) : '0;
			rsp_content_y  <= hit ? asa_pkg::COORD_W'(new_y + FW'(1)) : '0;
		end
	end

	`ASA_CHECK(a_open_bound, clk, arst_n, open_pages_q <= OW'(PAGE_LIMIT), "open page count past limit")
	`ASA_CHECK(a_kind_sum, clk, arst_n, ((OW + 1)'(cnt_img_q) + (OW + 1)'(cnt_gly_q)) == (OW + 1)'(open_pages_q), "kind counters disagree with open pages")
	`ASA_CHECK_NEXT(a_open_step, clk, arst_n, cmd.step && open_now, open_pages_q == OW'($past(open_pages_q) + 1'b1), "page open not counted")

endmodule

// ===== rtl/core/atlas_shelf_allocator.sv =====
// shelf allocator top level: an item is accepted, then takes one walk step per page
// visited, up to PAGE_LIMIT + 1 steps; the walk visits one page table entry per cycle
// but holds on its last entry while the prior result waits; a clear resets the counters
// a new word is taken once the walk is done, even while the last result waits
// arst_n empties the atlas and sets pages_per_kind_limit to 4; no clearing pass
// depends on asa_pkg, asa_ifs, asa_ctrl, asa_datapath
module atlas_shelf_allocator #(
	parameter int PAGE_EDGE  = 1024,
	parameter int PAGE_LIMIT = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	asa_req_if.sink                     req,
	asa_rsp_if.source                   rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [asa_pkg::LIMIT_W-1:0] cfg_data
);

	asa_pkg::cmd_t    cmd;
	asa_pkg::status_t status;

	// the limit register is always free to take a word
	assign cfg_ready = 1'b1;

	// controller: idle / walk sequencing and the result valid flag
	asa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath: page table, shelf fit test, counters and result payload
	asa_datapath #(
		.PAGE_EDGE  (PAGE_EDGE),
		.PAGE_LIMIT (PAGE_LIMIT)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_data           (cfg_data),
		.req_func           (req.func),
		.req_glyph          (req.glyph),
		.req_content_width  (req.content_width),
		.req_content_height (req.content_height),
		.rsp_placed         (rsp.placed),
		.rsp_page_index     (rsp.page_index),
		.rsp_content_x      (rsp.content_x),
		.rsp_content_y      (rsp.content_y)
	);

endmodule
